// ===== rtl/ttd_pkg.sv =====
// Package: formats, constants and texel conversion helpers for the texel decoder.
package ttd_pkg;

    localparam int MaxDimDefault     = 1024;
    localparam int PaletteDepthDefault = 16384;

    typedef enum logic [3:0] {
        FMT_I4     = 4'd0,
        FMT_I8     = 4'd1,
        FMT_IA4    = 4'd2,
        FMT_IA8    = 4'd3,
        FMT_RGB565 = 4'd4,
        FMT_RGB5A3 = 4'd5,
        FMT_RGBA8  = 4'd6,
        FMT_C4     = 4'd7,
        FMT_C8     = 4'd8,
        FMT_C14X2  = 4'd9,
        FMT_CMPR   = 4'd10
    } tex_fmt_t;

    localparam logic [1:0] PAL_IA8    = 2'd0;
    localparam logic [1:0] PAL_RGB565 = 2'd1;
    localparam logic [1:0] PAL_RGB5A3 = 2'd2;

    localparam logic [1:0] REG_TEX_FMT = 2'd0;
    localparam logic [1:0] REG_PAL_FMT = 2'd1;
    localparam logic [1:0] REG_WIDTH   = 2'd2;
    localparam logic [1:0] REG_HEIGHT  = 2'd3;

    localparam logic       ACT_DECODE  = 1'b0;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    function automatic logic [7:0] x3to8(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

    function automatic logic [7:0] x4to8(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] x5to8(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] x6to8(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic rgba_t rgb565_to(input logic [15:0] v);
        rgba_t c;
        c.r = x5to8(v[15:11]);
        c.g = x6to8(v[10:5]);
        c.b = x5to8(v[4:0]);
        c.a = 8'hFF;
        return c;
    endfunction

    function automatic rgba_t rgb5a3_to(input logic [15:0] v);
        rgba_t c;
        if (v[15])
        begin
            c.r = x5to8(v[14:10]);
            c.g = x5to8(v[9:5]);
            c.b = x5to8(v[4:0]);
            c.a = 8'hFF;
        end
        else
        begin
            c.r = x4to8(v[11:8]);
            c.g = x4to8(v[7:4]);
            c.b = x4to8(v[3:0]);
            c.a = x3to8(v[14:12]);
        end
        return c;
    endfunction

    function automatic logic [7:0] blend38(input logic [7:0] a, input logic [7:0] b);
        logic [10:0] s;
        s = 11'(a) * 11'd3 + 11'(b) * 11'd5;
        return s[10:3];
    endfunction

endpackage

// ===== rtl/ttd_if.sv =====
// Interfaces: valid/ready channels for source items, texel items and register writes.
interface ttd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] source_word;
    logic [13:0] palette_index;
    logic [15:0] palette_entry;
    modport source (output valid, action, source_word, palette_index, palette_entry,
                    input ready);
    modport sink (input valid, action, source_word, palette_index, palette_entry,
                  output ready);
endinterface

interface ttd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [9:0] texel_x;
    logic [9:0] texel_y;
    logic       run_last;
    logic       image_done;
    modport source (output valid, red, green, blue, alpha, texel_x, texel_y, run_last,
                    image_done, input ready);
    modport sink (input valid, red, green, blue, alpha, texel_x, texel_y, run_last,
                  image_done, output ready);
endinterface

interface ttd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tiled_texture_texel_decoder.sv =====
// Top level: tiled texture decoder, one texel per cycle unless stalled, from a word buffer and palette RAM.
//
//  channel | dir | carries
//  src     | in  | decode word or palette write
//  tex     | out | RGBA8 texel with x, y, run_last, image_done
//  cfg     | in  | register index and data
//
// A word is taken into a slot, then walked one texel position per cycle while the
// pipeline is not stalled (16 positions for I4, C4 and CMPR, 8 or 4 for others, none
// for an RGBA8 alpha/red word); the next word is taken in the cycle the walk finishes.
// Positions in padding are skipped. Paletted texels pass through the palette RAM, whose
// registered read forms a second stage in front of the output register, so each texel
// passes through stage 1 and then the output register after its position is walked.
// Reset clears control only.
module tiled_texture_texel_decoder #(
    parameter int MAX_DIM       = ttd_pkg::MaxDimDefault,
    parameter int PALETTE_DEPTH = ttd_pkg::PaletteDepthDefault
) (
    input logic          clk,
    input logic          rst_n,
    ttd_in_if.sink       src,
    ttd_out_if.source    tex,
    ttd_cfg_if.sink      cfg
);
    import ttd_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = $clog2(PALETTE_DEPTH);

    // registers
    logic [3:0]  tex_fmt_reg;
    logic [1:0]  pal_fmt_reg;
    logic [10:0] width_reg, height_reg;
    logic [DW-1:0] eff_w, eff_h;

    logic [9:0]  tcol_reg, trow_reg;
    logic [2:0]  wit_reg;
    logic [63:0] ar_rows_reg [4];

    // walk slot
    logic        busy_reg;
    logic [63:0] word_reg;
    logic [3:0]  fmt_reg;
    logic [2:0]  wi_reg;
    logic [DW+2:0] x0_reg, y0_reg;
    logic [63:0] ar_reg;
    logic [4:0]  pos_reg;
    logic [4:0]  npos;
    logic [15:0] emit_mask;
    logic [4:0]  last_pos;

    // stage 1 (palette lookup)
    logic        s1_valid_reg;
    logic        s1_pal_reg;
    rgba_t       s1_col_reg;
    logic [9:0]  s1_x_reg, s1_y_reg;
    logic        s1_last_reg, s1_done_reg;
    logic [15:0] pal_q_reg;
    logic        pal_oob_reg;
    logic [1:0]  s1_pfmt_reg;

    // output register
    logic        o_valid_reg;
    rgba_t       o_col_reg;
    logic [9:0]  o_x_reg, o_y_reg;
    logic        o_last_reg, o_done_reg;

    logic [15:0] palette_mem [PALETTE_DEPTH];

    function automatic logic [DW-1:0] clampd(input logic [10:0] v);
        if (v == 11'd0)
            return DW'(1);
        else if (32'(v) > MAX_DIM)
            return DW'(MAX_DIM);
        else
            return DW'(v);
    endfunction

    assign eff_w = clampd(width_reg);
    assign eff_h = clampd(height_reg);

    // pipeline flow
    logic adv1, adv0;
    assign adv1 = !o_valid_reg || tex.ready;
    assign adv0 = !s1_valid_reg || adv1;

    logic walk_end;
    logic accept;
    assign cfg.ready = 1'b1;
    assign src.ready = !busy_reg || (adv0 && walk_end);
    assign accept = src.valid && src.ready;

    // tile geometry for the current format
    logic [3:0] tw, th, words;
    always_comb
    begin
        tw = 4'd4;
        th = 4'd4;
        words = 4'd4;
        if (tex_fmt_reg inside {FMT_I4, FMT_I8, FMT_IA4, FMT_C4, FMT_C8, FMT_CMPR})
            tw = 4'd8;
        if (tex_fmt_reg inside {FMT_I4, FMT_C4, FMT_CMPR})
            th = 4'd8;
        if (tex_fmt_reg == FMT_RGBA8)
            words = 4'd8;
    end

    logic [DW+2:0] cur_x0, cur_y0;
    assign cur_x0 = (tw == 4'd8) ? (DW+3)'({tcol_reg, 3'b000}) : (DW+3)'({tcol_reg, 2'b00});
    assign cur_y0 = (th == 4'd8) ? (DW+3)'({trow_reg, 3'b000}) : (DW+3)'({trow_reg, 2'b00});

    logic decode_ok;
    assign decode_ok = (src.action == ACT_DECODE) && (tex_fmt_reg <= 4'(FMT_CMPR));

    // texel position count of the slot's format
    function automatic logic [4:0] count_of(input logic [3:0] f, input logic [2:0] wi);
        case (f)
            FMT_I4, FMT_C4, FMT_CMPR: return 5'd16;
            FMT_I8, FMT_IA4, FMT_C8:  return 5'd8;
            FMT_RGBA8:                return wi[2] ? 5'd4 : 5'd0;
            default:                  return 5'd4;
        endcase
    endfunction

    // coordinates of position p in the slot
    function automatic logic [2*(DW+3)-1:0] pos_xy(input logic [3:0] f, input logic [2:0] wi,
                                                   input logic [3:0] p,
                                                   input logic [DW+2:0] bx,
                                                   input logic [DW+2:0] by);
        logic [DW+2:0] x, y;
        case (f)
            FMT_I4, FMT_C4:
            begin
                x = bx + (DW+3)'(p[2:0]);
                y = by + (DW+3)'({wi[1:0], p[3]});
            end
            FMT_CMPR:
            begin
                x = bx + (DW+3)'({wi[0], p[1:0]});
                y = by + (DW+3)'({wi[1], p[3:2]});
            end
            FMT_I8, FMT_IA4, FMT_C8:
            begin
                x = bx + (DW+3)'(p[2:0]);
                y = by + (DW+3)'(wi[1:0]);
            end
            default:
            begin
                x = bx + (DW+3)'(p[1:0]);
                y = by + (DW+3)'(wi[1:0]);
            end
        endcase
        return {x, y};
    endfunction

    // in-image mask over positions, and index of the last valid one
    always_comb
    begin
        logic [DW+2:0] px, py;
        logic [4:0] cnt;
        cnt = count_of(fmt_reg, wi_reg);
        last_pos = 5'd0;
        for (int p = 0; p < 16; p++)
        begin
            {px, py} = pos_xy(fmt_reg, wi_reg, 4'(p), x0_reg, y0_reg);
            emit_mask[p] = (5'(p) < cnt) && (px < (DW+3)'(eff_w)) && (py < (DW+3)'(eff_h));
            if (emit_mask[p])
                last_pos = 5'(p);
        end
    end

    // next valid position at or after pos_reg (16 = none)
    always_comb
    begin
        npos = 5'd16;
        for (int p = 15; p >= 0; p--)
        begin
            if (emit_mask[p] && 5'(p) >= pos_reg)
                npos = 5'(p);
        end
    end

    assign walk_end = (npos == 5'd16) || (npos == last_pos);
    logic emit_now;
    assign emit_now = busy_reg && (npos != 5'd16) && adv0;

    // texel value at npos
    rgba_t  direct_col;
    logic   need_pal;
    logic [13:0] pal_idx;
    always_comb
    begin
        logic [3:0] p;
        logic [7:0] b, hi, lo, arh, arl;
        logic [15:0] v, c1, c2;
        rgba_t p0, p1, p2, p3;
        logic [1:0] k;
        p = npos[3:0];
        b = word_reg[63 - 8*p[3:1] -: 8];
        hi = word_reg[63 - 16*p[1:0] -: 8];
        lo = word_reg[55 - 16*p[1:0] -: 8];
        arh = ar_reg[63 - 16*p[1:0] -: 8];
        arl = ar_reg[55 - 16*p[1:0] -: 8];
        v = {hi, lo};
        c1 = word_reg[63:48];
        c2 = word_reg[47:32];
        p0 = rgb565_to(c1);
        p1 = rgb565_to(c2);
        if (c1 > c2)
        begin
            p2 = '{blend38(p1.r, p0.r), blend38(p1.g, p0.g), blend38(p1.b, p0.b), 8'hFF};
            p3 = '{blend38(p0.r, p1.r), blend38(p0.g, p1.g), blend38(p0.b, p1.b), 8'hFF};
        end
        else
        begin
            p2.r = 8'((9'(p0.r) + 9'(p1.r)) >> 1);
            p2.g = 8'((9'(p0.g) + 9'(p1.g)) >> 1);
            p2.b = 8'((9'(p0.b) + 9'(p1.b)) >> 1);
            p2.a = 8'hFF;
            p3 = p2;
            p3.a = 8'h00;
        end
        k = word_reg[31 - 8*p[3:2] - 2*p[1:0] -: 2];
        direct_col = '0;
        need_pal = 1'b0;
        pal_idx = '0;
        case (fmt_reg)
            FMT_I4:
            begin
                direct_col.r = x4to8(p[0] ? word_reg[59 - 8*p[3:1] -: 4]
                                          : word_reg[63 - 8*p[3:1] -: 4]);
                direct_col.g = direct_col.r;
                direct_col.b = direct_col.r;
                direct_col.a = direct_col.r;
            end
            FMT_C4:
            begin
                need_pal = 1'b1;
                pal_idx = 14'(p[0] ? word_reg[59 - 8*p[3:1] -: 4]
                                   : word_reg[63 - 8*p[3:1] -: 4]);
            end
            FMT_I8:
            begin
                b = word_reg[63 - 8*p[2:0] -: 8];
                direct_col = '{b, b, b, b};
            end
            FMT_IA4:
            begin
                b = word_reg[63 - 8*p[2:0] -: 8];
                direct_col = '{x4to8(b[3:0]), x4to8(b[3:0]), x4to8(b[3:0]), x4to8(b[7:4])};
            end
            FMT_C8:
            begin
                need_pal = 1'b1;
                pal_idx = 14'(word_reg[63 - 8*p[2:0] -: 8]);
            end
            FMT_IA8:    direct_col = '{lo, lo, lo, hi};
            FMT_RGB565: direct_col = rgb565_to(v);
            FMT_RGB5A3: direct_col = rgb5a3_to(v);
            FMT_C14X2:
            begin
                need_pal = 1'b1;
                pal_idx = v[13:0];
            end
            FMT_RGBA8:  direct_col = '{arl, hi, lo, arh};
            FMT_CMPR:
            begin
                case (k)
                    2'd0:    direct_col = p0;
                    2'd1:    direct_col = p1;
                    2'd2:    direct_col = p2;
                    default: direct_col = p3;
                endcase
            end
            default:    direct_col = '0;
        endcase
    end

    logic [DW+2:0] nx, ny;
    assign {nx, ny} = pos_xy(fmt_reg, wi_reg, npos[3:0], x0_reg, y0_reg);

    // control registers and tile walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_fmt_reg <= 4'(FMT_I4);
            pal_fmt_reg <= PAL_IA8;
            width_reg <= 11'd1;
            height_reg <= 11'd1;
            tcol_reg <= '0;
            trow_reg <= '0;
            wit_reg <= '0;
            busy_reg <= 1'b0;
            pos_reg <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TEX_FMT: tex_fmt_reg <= cfg.data[3:0];
                    REG_PAL_FMT: pal_fmt_reg <= cfg.data[1:0];
                    REG_WIDTH:   width_reg <= cfg.data;
                    REG_HEIGHT:  height_reg <= cfg.data;
                    default:     ;
                endcase
                tcol_reg <= '0;
                trow_reg <= '0;
                wit_reg <= '0;
            end
            if (busy_reg && adv0)
            begin
                if (walk_end)
                    busy_reg <= 1'b0;
                else
                    pos_reg <= npos + 5'd1;
            end
            if (accept && decode_ok)
            begin
                busy_reg <= 1'b1;
                pos_reg <= '0;
                if ({1'b0, wit_reg} + 4'd1 >= words)
                begin
                    wit_reg <= '0;
                    if ((DW+3)'(cur_x0) + (DW+3)'(tw) >= (DW+3)'(eff_w))
                    begin
                        tcol_reg <= '0;
                        if ((DW+3)'(cur_y0) + (DW+3)'(th) >= (DW+3)'(eff_h))
                            trow_reg <= '0;
                        else
                            trow_reg <= trow_reg + 10'd1;
                    end
                    else
                        tcol_reg <= tcol_reg + 10'd1;
                end
                else
                    wit_reg <= wit_reg + 3'd1;
            end
            if (adv0)
                s1_valid_reg <= emit_now;
            if (adv1)
                o_valid_reg <= s1_valid_reg;
        end
    end

    // slot payload and A/R row buffer
    always_ff @(posedge clk)
    begin
        if (accept && decode_ok)
        begin
            word_reg <= src.source_word;
            fmt_reg <= tex_fmt_reg;
            wi_reg <= wit_reg;
            x0_reg <= cur_x0;
            y0_reg <= cur_y0;
            ar_reg <= ar_rows_reg[wit_reg[1:0]];
            if (tex_fmt_reg == 4'(FMT_RGBA8) && !wit_reg[2])
                ar_rows_reg[wit_reg[1:0]] <= src.source_word;
        end
    end

    // palette memory: written by palette items, read for paletted texels
    always_ff @(posedge clk)
    begin
        if (accept && src.action != ACT_DECODE && 32'(src.palette_index) < PALETTE_DEPTH)
            palette_mem[PW'(src.palette_index)] <= src.palette_entry;
        if (adv0)
        begin
            pal_q_reg <= palette_mem[PW'(pal_idx)];
            pal_oob_reg <= 32'(pal_idx) >= PALETTE_DEPTH;
            s1_pal_reg <= need_pal;
            s1_pfmt_reg <= pal_fmt_reg;
            s1_col_reg <= direct_col;
            s1_x_reg <= nx[9:0];
            s1_y_reg <= ny[9:0];
            s1_last_reg <= walk_end;
            s1_done_reg <= (nx == (DW+3)'(eff_w) - 1'b1) && (ny == (DW+3)'(eff_h) - 1'b1);
        end
    end

    rgba_t pal_col;
    always_comb
    begin
        logic [15:0] e;
        e = pal_oob_reg ? 16'd0 : pal_q_reg;
        case (s1_pfmt_reg)
            PAL_IA8:    pal_col = '{e[7:0], e[7:0], e[7:0], e[15:8]};
            PAL_RGB565: pal_col = rgb565_to(e);
            PAL_RGB5A3: pal_col = rgb5a3_to(e);
            default:    pal_col = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            o_col_reg <= s1_pal_reg ? pal_col : s1_col_reg;
            o_x_reg <= s1_x_reg;
            o_y_reg <= s1_y_reg;
            o_last_reg <= s1_last_reg;
            o_done_reg <= s1_done_reg;
        end
    end

    assign tex.valid = o_valid_reg;
    assign tex.red = o_col_reg.r;
    assign tex.green = o_col_reg.g;
    assign tex.blue = o_col_reg.b;
    assign tex.alpha = o_col_reg.a;
    assign tex.texel_x = o_x_reg;
    assign tex.texel_y = o_y_reg;
    assign tex.run_last = o_last_reg;
    assign tex.image_done = o_done_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tex.valid && !tex.ready |=> tex.valid && $stable(tex.texel_x))
        else $error("texel dropped under stall");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !walk_end |-> !src.ready)
        else $error("item accepted mid-walk");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        tex.valid && tex.image_done |-> tex.run_last)
        else $error("image_done without run_last");
`endif

endmodule
